// ===== rtl/vdtp_pkg.sv =====
package vdtp_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIN
    } t_state;

    // Configuration register indexes (byte address / 4)
    localparam int CFG_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_FINE_X = 2'd0,
        REG_FINE_Y = 2'd1,
        REG_FINE_Z = 2'd2
    } t_reg_idx;

    // Item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Fixed widths of the item fields
    localparam int POS_W   = 6;
    localparam int DENS_W  = 16;
    localparam int SIZE_W  = 7;
    localparam int WGT_W   = 7;   // corner weight product, up to 64
    localparam int QW_W    = 3;   // per-axis weight in quarters, up to 4
    localparam int CORNERS = 8;

    // Control from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    // Two taps of one axis with their weights in quarters
    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [QW_W-1:0]  wlo;
        logic [QW_W-1:0]  whi;
    } t_tap;

    // Taps for fine index i on an axis of nc coarse cells (nc >= 1)
    function automatic t_tap axis_taps(input logic [POS_W-1:0] i,
                                       input logic [SIZE_W-1:0] nc);
        t_tap             t;
        logic [POS_W-1:0] m;
        logic [POS_W-1:0] last;
        m    = i >> 1;
        last = POS_W'(nc - SIZE_W'(1));
        if (i == '0) begin
            t.lo  = '0;
            t.hi  = '0;
            t.wlo = QW_W'(4);
            t.whi = '0;
        end else if (!i[0]) begin
            t.lo  = m - POS_W'(1);
            t.hi  = m;
            t.wlo = QW_W'(1);
            t.whi = QW_W'(3);
        end else begin
            t.lo  = m;
            t.hi  = m + POS_W'(1);
            t.wlo = QW_W'(3);
            t.whi = QW_W'(1);
        end
        // clamp both taps to the last coarse cell
        if (t.hi > last) t.hi = last;
        if (t.lo > last) t.lo = last;
        return t;
    endfunction

endpackage

// ===== rtl/vdtp_ram.sv =====
module vdtp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vdtp_mac.sv =====
module vdtp_mac
    import vdtp_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int ACC_W  = 23
) (
    input  logic              i_clk,
    input  t_mac_ctl          i_ctl,
    input  logic [WGT_W-1:0]  i_weight,
    input  logic [DATA_W-1:0] i_data,
    output logic [ACC_W-1:0]  o_acc
);

    localparam int PROD_W = DATA_W + WGT_W;

    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  r_acc;

    // Weight one corner value
    assign w_prod = (PROD_W)'(i_data) * (PROD_W)'(i_weight);

    // Clear at item start, add one corner per beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= r_acc + (ACC_W)'(w_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/voxel_density_trilinear_prolong.sv =====
// Channel  | Handshake                          | Payload
// ---------+------------------------------------+------------------------------------
// item in  | start, busy (accept: start & !busy) | i_op, i_pos_x/y/z, i_density_in
// result   | o_done strobe, one cycle           | o_density_out, o_out_of_range
// config   | psel/penable/pwrite/pready         | paddr, pwdata, prdata
//
// A write or an out-of-range item goes from accept through setup and finish to the edge
// that takes o_done; a sample goes through setup, corner reads from the single-port
// store into one shared multiply-accumulate unit, finish and the strobe cycle.
// busy is high from the cycle after accept until the strobe; the next item may be
// accepted while o_done is high. The receiver cannot stall: o_done lasts one cycle.
// Reset (synchronous, active low) sets the fine sizes to 64 and leaves the store as is.
module voxel_density_trilinear_prolong
    import vdtp_pkg::*;
#(
    parameter int MAX_COARSE_DIM = 32,
    parameter int DENSITY_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [POS_W-1:0]      i_pos_z,
    input  logic [DENS_W-1:0]     i_density_in,
    // result channel
    output logic                  o_done,
    output logic [DENS_W-1:0]     o_density_out,
    output logic                  o_out_of_range,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DEPTH   = MAX_COARSE_DIM * MAX_COARSE_DIM * MAX_COARSE_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W   = DENSITY_BITS + 7;
    localparam int RND_W   = ACC_W + 1;
    localparam int EFF_W   = SIZE_W + 1;
    localparam int CNT_W   = $clog2(CORNERS + 1);
    localparam int PLANE   = MAX_COARSE_DIM * MAX_COARSE_DIM;
    localparam logic [EFF_W-1:0] FINE_MAX = EFF_W'(2 * MAX_COARSE_DIM);
    localparam logic [DENSITY_BITS-1:0] DENS_ONE =
        DENSITY_BITS'(1) << (DENSITY_BITS - 1);

    // configuration registers
    logic [SIZE_W-1:0] r_fine_x, r_fine_y, r_fine_z;

    // sequencer
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // latched item
    logic                    r_op;
    logic [POS_W-1:0]        r_pos_x, r_pos_y, r_pos_z;
    logic [DENSITY_BITS-1:0] r_din;
    logic                    r_oor;
    t_tap                    r_tx, r_ty, r_tz;
    logic [WGT_W-1:0]        r_wprev;

    // result registers
    logic              r_done;
    logic [DENS_W-1:0] r_dout;
    logic              r_oor_out;

    // derived sizes and decode
    logic [EFF_W-1:0]  w_eff_x, w_eff_y, w_eff_z;
    logic [SIZE_W-1:0] w_nc_x, w_nc_y, w_nc_z;
    logic              w_oor;
    logic              w_accept;
    logic              w_cfg_wr;

    // store and MAC signals
    logic                    w_ram_we;
    logic [ADDR_W-1:0]       w_ram_addr;
    logic [DENSITY_BITS-1:0] w_ram_wdata;
    logic [DENSITY_BITS-1:0] w_ram_rdata;
    logic [DENSITY_BITS-1:0] w_din_sat;
    logic [POS_W-1:0]        w_cx, w_cy, w_cz;
    logic [WGT_W-1:0]        w_weight;
    t_mac_ctl                w_mac_ctl;
    logic [ACC_W-1:0]        w_acc;
    logic [RND_W-1:0]        w_rnd;
    logic [DENS_W-1:0]       n_dout;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign busy     = (r_state != S_IDLE);

    // Clamp fine sizes to 1..2*MAX and derive coarse sizes
    function automatic logic [EFF_W-1:0] eff_fine(input logic [SIZE_W-1:0] n);
        logic [EFF_W-1:0] e;
        e = EFF_W'(n);
        if (e == '0) e = EFF_W'(1);
        if (e > FINE_MAX) e = FINE_MAX;
        return e;
    endfunction

    assign w_eff_x = eff_fine(r_fine_x);
    assign w_eff_y = eff_fine(r_fine_y);
    assign w_eff_z = eff_fine(r_fine_z);
    assign w_nc_x  = SIZE_W'((w_eff_x + EFF_W'(1)) >> 1);
    assign w_nc_y  = SIZE_W'((w_eff_y + EFF_W'(1)) >> 1);
    assign w_nc_z  = SIZE_W'((w_eff_z + EFF_W'(1)) >> 1);

    // Range check against coarse size for writes, fine size for samples
    always_comb begin
        if (r_op == OP_WRITE) begin
            w_oor = (EFF_W'(r_pos_x) >= EFF_W'(w_nc_x)) ||
                    (EFF_W'(r_pos_y) >= EFF_W'(w_nc_y)) ||
                    (EFF_W'(r_pos_z) >= EFF_W'(w_nc_z));
        end else begin
            w_oor = (EFF_W'(r_pos_x) >= w_eff_x) ||
                    (EFF_W'(r_pos_y) >= w_eff_y) ||
                    (EFF_W'(r_pos_z) >= w_eff_z);
        end
    end

    // Saturate written density to one
    assign w_din_sat = (r_din > DENS_ONE) ? DENS_ONE : r_din;

    // Corner selected by the counter: bit 0 picks x, bit 1 y, bit 2 z
    assign w_cx = r_cnt[0] ? r_tx.hi : r_tx.lo;
    assign w_cy = r_cnt[1] ? r_ty.hi : r_ty.lo;
    assign w_cz = r_cnt[2] ? r_tz.hi : r_tz.lo;
    assign w_weight = WGT_W'(r_cnt[0] ? r_tx.whi : r_tx.wlo) *
                      WGT_W'(r_cnt[1] ? r_ty.whi : r_ty.wlo) *
                      WGT_W'(r_cnt[2] ? r_tz.whi : r_tz.wlo);

    // Store port: write in setup, corner reads while running
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = w_din_sat;
        if (r_state == S_PREP) begin
            w_ram_we   = (r_op == OP_WRITE) && !w_oor;
            w_ram_addr = ADDR_W'(32'(r_pos_z) * PLANE + 32'(r_pos_y) * MAX_COARSE_DIM
                                 + 32'(r_pos_x));
        end else begin
            w_ram_addr = ADDR_W'(32'(w_cz) * PLANE + 32'(w_cy) * MAX_COARSE_DIM
                                 + 32'(w_cx));
        end
    end

    // Round half up and drop the 1/64 scale
    assign w_rnd  = RND_W'(w_acc) + RND_W'(32);
    assign n_dout = ((r_op == OP_SAMPLE) && !r_oor) ? DENS_W'(w_rnd >> 6) : '0;

    // Sequencer next state and MAC control
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        w_mac_ctl.clr = 1'b0;
        w_mac_ctl.en  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_PREP;
            end
            S_PREP: begin
                w_mac_ctl.clr = 1'b1;
                n_cnt         = '0;
                if ((r_op == OP_SAMPLE) && !w_oor) n_state = S_RUN;
                else                              n_state = S_FIN;
            end
            S_RUN: begin
                // data for corner cnt-1 arrives while corner cnt is read
                w_mac_ctl.en = (r_cnt != '0);
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CORNERS)) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == S_FIN);
        end
    end

    // Latch the item and its decode
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_din   <= DENSITY_BITS'(i_density_in);
        end
        if (r_state == S_PREP) begin
            r_oor <= w_oor;
            r_tx  <= axis_taps(r_pos_x, w_nc_x);
            r_ty  <= axis_taps(r_pos_y, w_nc_y);
            r_tz  <= axis_taps(r_pos_z, w_nc_z);
        end
        r_wprev <= w_weight;
        if (r_state == S_FIN) begin
            r_dout    <= n_dout;
            r_oor_out <= r_oor;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_x <= SIZE_W'(64);
            r_fine_y <= SIZE_W'(64);
            r_fine_z <= SIZE_W'(64);
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_FINE_X: r_fine_x <= pwdata[SIZE_W-1:0];
                REG_FINE_Y: r_fine_y <= pwdata[SIZE_W-1:0];
                REG_FINE_Z: r_fine_z <= pwdata[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_FINE_X: prdata = 32'(r_fine_x);
            REG_FINE_Y: prdata = 32'(r_fine_y);
            REG_FINE_Z: prdata = 32'(r_fine_z);
            default:    prdata = '0;
        endcase
    end

    vdtp_ram #(
        .WIDTH (DENSITY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    vdtp_mac #(
        .DATA_W (DENSITY_BITS),
        .ACC_W  (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_weight (r_wprev),
        .i_data   (w_ram_rdata),
        .o_acc    (w_acc)
    );

    assign o_done         = r_done;
    assign o_density_out  = r_done ? r_dout : '0;
    assign o_out_of_range = r_done ? r_oor_out : 1'b0;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |-> (o_density_out == '0))
        else $error("out-of-range result carries nonzero density");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accept");

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result strobe without finish state");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= CNT_W'(CORNERS)))
        else $error("corner counter past last corner");

    a_write_only_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == S_PREP) && (r_op == OP_WRITE)))
        else $error("store written outside a write item");
`endif

endmodule

// ===== tb/tb_voxel_density_trilinear_prolong.sv =====
`timescale 1ns / 100ps

module tb_voxel_density_trilinear_prolong;
    import vdtp_pkg::*;

    localparam int COARSE_MAX     = 32;
    localparam int FINE_MAX       = 2 * COARSE_MAX;
    localparam int CELL_COUNT     = COARSE_MAX * COARSE_MAX * COARSE_MAX;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_PHASES     = 8;
    localparam int RANDOM_PER_PHASE = 28;
    localparam logic [DENS_W-1:0] DENSITY_ONE = 16'h8000;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [DENS_W-1:0] dens;
    } t_voxel_item;

    typedef struct packed {
        logic [DENS_W-1:0] dens;
        logic              oor;
    } t_voxel_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_op = OP_WRITE;
    logic [POS_W-1:0]      i_pos_x = '0;
    logic [POS_W-1:0]      i_pos_y = '0;
    logic [POS_W-1:0]      i_pos_z = '0;
    logic [DENS_W-1:0]     i_density_in = '0;
    logic                  o_done;
    logic [DENS_W-1:0]     o_density_out;
    logic                  o_out_of_range;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predictor state: fine sizes and the coarse field
    logic [SIZE_W-1:0] fine_cfg [3] = '{7'd64, 7'd64, 7'd64};
    logic [DENS_W-1:0] coarse_mem [CELL_COUNT];
    // Cells already covered by a queued in-range write
    bit                cell_queued [CELL_COUNT];

    t_voxel_item   voxel_item_q [$];
    t_voxel_result density_pred_q [$];

    int idle_pct;
    int win_base [3];
    int stall_cycles;
    int mismatches;
    int n_items, n_samples, n_writes, n_oor, n_settings;

    voxel_density_trilinear_prolong DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_density_in   (i_density_in),
        .o_done         (o_done),
        .o_density_out  (o_density_out),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Fine size in effect: zero counts as one, large values saturate
    function automatic int eff_size(input logic [SIZE_W-1:0] n);
        if (n < 1) return 1;
        if (n > FINE_MAX) return FINE_MAX;
        return int'(n);
    endfunction

    function automatic int coarse_size(input logic [SIZE_W-1:0] n);
        return (eff_size(n) + 1) / 2;
    endfunction

    function automatic int cell_index(input int x, input int y, input int z);
        return (z * COARSE_MAX + y) * COARSE_MAX + x;
    endfunction

    // Two coarse taps and their quarter weights for fine index i
    function automatic void get_taps(input int i, input int nc, output int lo,
                                     output int hi, output int wlo, output int whi);
        if (i == 0) begin
            lo = 0; hi = 0; wlo = 4; whi = 0;
        end else if (i % 2 == 0) begin
            lo = i / 2 - 1; hi = i / 2; wlo = 1; whi = 3;
        end else begin
            lo = i / 2; hi = i / 2 + 1; wlo = 3; whi = 1;
        end
        if (hi > nc - 1) hi = nc - 1;
        if (lo > nc - 1) lo = nc - 1;
    endfunction

    // Apply one item to the predicted field and return its result
    function automatic t_voxel_result prolong_predict(input t_voxel_item it);
        t_voxel_result r;
        int xs [2], ys [2], zs [2], wx [2], wy [2], wz [2];
        int acc;
        r.dens = '0;
        r.oor  = 1'b0;
        if (it.op == OP_WRITE) begin
            if (it.x >= coarse_size(fine_cfg[0]) || it.y >= coarse_size(fine_cfg[1]) ||
                it.z >= coarse_size(fine_cfg[2])) begin
                r.oor = 1'b1;
            end else begin
                coarse_mem[cell_index(it.x, it.y, it.z)] =
                    (it.dens > DENSITY_ONE) ? DENSITY_ONE : it.dens;
            end
        end else if (it.x >= eff_size(fine_cfg[0]) || it.y >= eff_size(fine_cfg[1]) ||
                     it.z >= eff_size(fine_cfg[2])) begin
            r.oor = 1'b1;
        end else begin
            get_taps(it.x, coarse_size(fine_cfg[0]), xs[0], xs[1], wx[0], wx[1]);
            get_taps(it.y, coarse_size(fine_cfg[1]), ys[0], ys[1], wy[0], wy[1]);
            get_taps(it.z, coarse_size(fine_cfg[2]), zs[0], zs[1], wz[0], wz[1]);
            acc = 0;
            for (int c = 0; c < 2; c++)
                for (int b = 0; b < 2; b++)
                    for (int a = 0; a < 2; a++)
                        acc += wx[a] * wy[b] * wz[c] *
                               int'(coarse_mem[cell_index(xs[a], ys[b], zs[c])]);
            r.dens = DENS_W'((acc + 32) >> 6);
        end
        return r;
    endfunction

    function automatic logic [DENS_W-1:0] pick_density();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DENSITY_ONE;
            2:       return '1;
            3:       return DENS_W'($urandom_range(65535));
            default: return DENS_W'($urandom_range(32768));
        endcase
    endfunction

    function automatic void queue_write(input int x, input int y, input int z,
                                        input logic [DENS_W-1:0] d);
        t_voxel_item it;
        it = '{op: OP_WRITE, x: POS_W'(x), y: POS_W'(y), z: POS_W'(z), dens: d};
        voxel_item_q.insert(voxel_item_q.size(), it);
        if (x < coarse_size(fine_cfg[0]) && y < coarse_size(fine_cfg[1]) &&
            z < coarse_size(fine_cfg[2]))
            cell_queued[cell_index(x, y, z)] = 1'b1;
    endfunction

    // Queue a sample; an in-range one is preceded by writes to any unset corner
    function automatic void queue_sample(input int x, input int y, input int z);
        t_voxel_item it;
        int xs [2], ys [2], zs [2], w [6];
        if (x < eff_size(fine_cfg[0]) && y < eff_size(fine_cfg[1]) &&
            z < eff_size(fine_cfg[2])) begin
            get_taps(x, coarse_size(fine_cfg[0]), xs[0], xs[1], w[0], w[1]);
            get_taps(y, coarse_size(fine_cfg[1]), ys[0], ys[1], w[2], w[3]);
            get_taps(z, coarse_size(fine_cfg[2]), zs[0], zs[1], w[4], w[5]);
            for (int c = 0; c < 2; c++)
                for (int b = 0; b < 2; b++)
                    for (int a = 0; a < 2; a++)
                        if (!cell_queued[cell_index(xs[a], ys[b], zs[c])])
                            queue_write(xs[a], ys[b], zs[c], pick_density());
        end
        it = '{op: OP_SAMPLE, x: POS_W'(x), y: POS_W'(y), z: POS_W'(z),
               dens: DENS_W'($urandom_range(65535))};
        voxel_item_q.insert(voxel_item_q.size(), it);
    endfunction

    // Fine coordinate, often inside a small window so that corners get reused
    function automatic int pick_fine(input int axis);
        int e, v;
        e = eff_size(fine_cfg[axis]);
        if ($urandom_range(1) == 0) begin
            v = win_base[axis] + $urandom_range(3);
            return (v > e - 1) ? e - 1 : v;
        end
        return $urandom_range(e - 1);
    endfunction

    function automatic void queue_random_item();
        int r, ax;
        int p [3];
        r = $urandom_range(99);
        for (int k = 0; k < 3; k++) p[k] = $urandom_range(FINE_MAX - 1);
        ax = $urandom_range(2);
        if (r < 50) begin
            queue_sample(pick_fine(0), pick_fine(1), pick_fine(2));
        end else if (r < 80) begin
            queue_write($urandom_range(coarse_size(fine_cfg[0]) - 1),
                        $urandom_range(coarse_size(fine_cfg[1]) - 1),
                        $urandom_range(coarse_size(fine_cfg[2]) - 1), pick_density());
        end else if (r >= 90 && eff_size(fine_cfg[ax]) < FINE_MAX) begin
            p[ax] = $urandom_range(FINE_MAX - 1, eff_size(fine_cfg[ax]));
            queue_sample(p[0], p[1], p[2]);
        end else begin
            p[ax] = $urandom_range(FINE_MAX - 1, coarse_size(fine_cfg[ax]));
            queue_write(p[0], p[1], p[2], pick_density());
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Register write with a setup and an access phase; the predictor takes the value at the access edge
    task automatic cfg_write(input t_reg_idx idx, input logic [SIZE_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fine_cfg[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every queued beat has been accepted and answered
    task automatic wait_drained();
        do @(posedge i_clk); while (voxel_item_q.size() != 0 || density_pred_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: hold a beat until accepted, then present the next or idle
    always @(posedge i_clk) begin
        t_voxel_item   nxt;
        t_voxel_result res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                nxt = voxel_item_q.pop_front();
                res = prolong_predict(nxt);
                density_pred_q.insert(density_pred_q.size(), res);
                n_items++;
                if (res.oor) n_oor++;
                else if (nxt.op == OP_SAMPLE) n_samples++;
                else n_writes++;
            end
            if (start && busy) begin
                // hold the current beat
            end else if (voxel_item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = voxel_item_q[0];
                start        <= 1'b1;
                i_op         <= nxt.op;
                i_pos_x      <= nxt.x;
                i_pos_y      <= nxt.y;
                i_pos_z      <= nxt.z;
                i_density_in <= nxt.dens;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_voxel_result exp_r;
        if (i_rst_n && o_done) begin
            if (density_pred_q.size() == 0) begin
                note_mismatch($sformatf("result with no item pending: density %0d oor %0b",
                                        o_density_out, o_out_of_range));
            end else begin
                exp_r = density_pred_q.pop_front();
                if (o_density_out !== exp_r.dens || o_out_of_range !== exp_r.oor)
                    note_mismatch($sformatf("density exp %0d got %0d, oor exp %0b got %0b",
                                            exp_r.dens, o_density_out, exp_r.oor,
                                            o_out_of_range));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [SIZE_W-1:0] phase_cfg [NUM_PHASES][3];
        int e [3];
        int c [3];
        phase_cfg = '{
            '{7'd64, 7'd64, 7'd64}, '{7'd1, 7'd1, 7'd1}, '{7'd0, 7'd0, 7'd0},
            '{7'd2, 7'd3, 7'd4}, '{7'd127, 7'd65, 7'd100}, '{7'd5, 7'd17, 7'd33},
            '{7'd63, 7'd2, 7'd64}, '{7'd0, 7'd0, 7'd0}
        };
        for (int k = 0; k < 3; k++) phase_cfg[NUM_PHASES-1][k] = SIZE_W'($urandom_range(127));
        idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // reprogram the sizes while idle; the first phase keeps the reset values
            if (ph != 0) begin
                cfg_write(REG_FINE_X, phase_cfg[ph][0]);
                cfg_write(REG_FINE_Y, phase_cfg[ph][1]);
                cfg_write(REG_FINE_Z, phase_cfg[ph][2]);
            end
            n_settings++;
            case (ph % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                2:       idle_pct = 0;
                default: idle_pct = 28;
            endcase
            for (int k = 0; k < 3; k++) begin
                e[k] = eff_size(fine_cfg[k]);
                c[k] = coarse_size(fine_cfg[k]);
                win_base[k] = $urandom_range(e[k] - 1);
            end

            // directed: grid corners, saturation and out-of-range beats
            if (ph == 0) begin
                queue_write(0, 0, 0, DENSITY_ONE);
                queue_write(1, 0, 0, 16'hFFFF);
                queue_write(2, 0, 0, 16'h0000);
                queue_write(31, 31, 31, 16'h7FFF);
                queue_sample(1, 0, 0);
                queue_sample(2, 0, 0);
                queue_sample(3, 1, 0);
                queue_write(63, 63, 63, 16'hFFFF);
            end
            queue_write(c[0] - 1, c[1] - 1, c[2] - 1, DENSITY_ONE);
            queue_sample(0, 0, 0);
            queue_sample(e[0] - 1, e[1] - 1, e[2] - 1);
            queue_write(c[0], 0, 0, 16'h5555);
            queue_write(0, 0, FINE_MAX - 1, 16'hAAAA);
            if (e[0] < FINE_MAX) queue_sample(e[0], 0, 0);
            if (e[1] < FINE_MAX) queue_sample(0, FINE_MAX - 1, 0);

            for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_random_item();
            wait_drained();
        end

        if (density_pred_q.size() != 0) note_mismatch("results still outstanding at end");
        $display("Ran %0d beats: %0d samples, %0d writes, %0d out of range", n_items,
                 n_samples, n_writes, n_oor);
        $display("Covered %0d fine size settings with %0d mismatches", n_settings,
                 mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
